// ===== design/mcgp_pkg.sv =====
// Package for the cloud group parser: payload structs, parser state struct
// and the sky-cover and cloud-type code tables. No dependencies.
`default_nettype none

package mcgp_pkg;

    localparam int unsigned MAX_TOKEN_LEN = 16;
    localparam int unsigned POS_W         = 5;
    localparam int unsigned ALT_W         = 10;
    localparam int unsigned N_COVER       = 7;
    localparam int unsigned N_TYPE        = 3;
    localparam int unsigned ALT_MAX       = 999;

    typedef enum logic [2:0] {
        COVER_SKC = 3'd0,
        COVER_CLR = 3'd1,
        COVER_NSC = 3'd2,
        COVER_FEW = 3'd3,
        COVER_SCT = 3'd4,
        COVER_BKN = 3'd5,
        COVER_OVC = 3'd6
    } cover_code_t;

    typedef enum logic [1:0] {
        CTYPE_TCU = 2'd0,
        CTYPE_CB  = 2'd1,
        CTYPE_ACC = 2'd2
    } ctype_code_t;

    // Index [code][char] with char 0 the leftmost letter.
    localparam logic [0:N_COVER-1][0:2][7:0] COVER_CODES =
        {"SKC", "CLR", "NSC", "FEW", "SCT", "BKN", "OVC"};
    localparam logic [0:N_TYPE-1][0:2][7:0] TYPE_CODES =
        {"TCU", "CB", 8'h00, "ACC"};
    localparam logic [0:N_TYPE-1][1:0] TYPE_LENS = {2'd3, 2'd2, 2'd3};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       temporary;
    } mcgp_in_t;

    typedef struct packed {
        logic             matched;
        logic [2:0]       cover_res;
        logic             has_altitude;
        logic [ALT_W-1:0] altitude;
        logic             has_type;
        logic [1:0]       cloud_type;
        logic             temp_out;
    } mcgp_out_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [N_COVER-1:0] cover_cand;
        logic [ALT_W-1:0]   alt_accum;
        logic               digits_open;
        logic [N_TYPE-1:0]  type_cand;
        logic               temp_latched;
    } mcgp_state_t;

    localparam mcgp_state_t STATE_RESET = '{
        position:     '0,
        cover_cand:   '1,
        alt_accum:    '0,
        digits_open:  1'b1,
        type_cand:    '1,
        temp_latched: 1'b0
    };

endpackage

`default_nettype wire

// ===== design/mcgp_step.sv =====
// Per-character update of the parser state and decode of the result on the
// final character. Pure combinational logic; uses mcgp_pkg.
`default_nettype none

module mcgp_step (
    input  wire mcgp_pkg::mcgp_state_t state,
    input  wire mcgp_pkg::mcgp_in_t    item,
    output mcgp_pkg::mcgp_state_t      state_next,
    output mcgp_pkg::mcgp_out_t        result
);
    import mcgp_pkg::*;

    logic [POS_W-1:0]   idx;
    logic [POS_W-1:0]   k;
    logic [POS_W-1:0]   type_len;
    logic               in_range;
    logic               is_digit;
    logic [13:0]        alt_sum;
    logic [N_COVER-1:0] cover_cand;
    logic [N_TYPE-1:0]  type_cand;
    logic [ALT_W-1:0]   alt_accum;
    logic               digits_open;
    logic               len_ge3;
    logic               len_gt3;
    logic               len_gt6;
    logic               any_cover;
    logic [2:0]         cover_sel;
    logic               any_type;
    logic [1:0]         type_sel;

    assign idx      = state.position;
    assign in_range = idx < POS_W'(MAX_TOKEN_LEN);
    assign k        = idx - POS_W'(6);
    assign is_digit = (item.ch >= "0") && (item.ch <= "9");
    assign alt_sum  = {1'b0, state.alt_accum, 3'b000} + {3'b000, state.alt_accum, 1'b0}
                      + {6'd0, item.ch - 8'h30};

    always_comb
    begin
        cover_cand  = state.cover_cand;
        type_cand   = state.type_cand;
        alt_accum   = state.alt_accum;
        digits_open = state.digits_open;
        if (!in_range)
        begin
            digits_open = 1'b0;
            type_cand   = '0;
        end
        else
        begin
            if (idx < POS_W'(3))
            begin
                for (int j = 0; j < N_COVER; j++)
                begin
                    if (item.ch != COVER_CODES[j][idx[1:0]])
                        cover_cand[j] = 1'b0;
                end
            end
            else if (state.digits_open)
            begin
                if (is_digit)
                    alt_accum = (alt_sum > 14'(ALT_MAX)) ? ALT_W'(ALT_MAX)
                                                        : alt_sum[ALT_W-1:0];
                else
                    digits_open = 1'b0;
            end
            if (idx >= POS_W'(6))
            begin
                for (int j = 0; j < N_TYPE; j++)
                begin
                    if (k >= POS_W'(TYPE_LENS[j]))
                        type_cand[j] = 1'b0;
                    else if (item.ch != TYPE_CODES[j][k[1:0]])
                        type_cand[j] = 1'b0;
                end
            end
        end
    end

    // Lowest index wins for both cover and type.
    always_comb
    begin
        any_cover = |cover_cand;
        cover_sel = '0;
        for (int j = N_COVER - 1; j >= 0; j--)
        begin
            if (cover_cand[j])
                cover_sel = 3'(j);
        end
    end

    // Text from position 6 on is idx-5 characters long including this one.
    assign type_len = idx - POS_W'(5);

    always_comb
    begin
        any_type = 1'b0;
        type_sel = '0;
        for (int j = N_TYPE - 1; j >= 0; j--)
        begin
            if (type_cand[j] && (type_len == POS_W'(TYPE_LENS[j])))
            begin
                any_type = 1'b1;
                type_sel = 2'(j);
            end
        end
    end

    assign len_ge3 = idx >= POS_W'(2);
    assign len_gt3 = idx >= POS_W'(3);
    assign len_gt6 = idx >= POS_W'(6);

    always_comb
    begin
        result.matched      = len_ge3 && any_cover;
        result.cover_res    = result.matched ? cover_sel : 3'(COVER_SKC);
        result.has_altitude = result.matched && len_gt3;
        result.altitude     = result.has_altitude ? alt_accum : '0;
        result.has_type     = result.matched && len_gt6 && any_type;
        result.cloud_type   = result.has_type ? type_sel : 2'(CTYPE_TCU);
        result.temp_out     = (idx == '0) ? item.temporary : state.temp_latched;
    end

    // Return to the reset state after the final character.
    always_comb
    begin
        if (item.last)
            state_next = STATE_RESET;
        else
        begin
            state_next.position     = (&idx) ? idx : idx + POS_W'(1);
            state_next.cover_cand   = cover_cand;
            state_next.alt_accum    = alt_accum;
            state_next.digits_open  = digits_open;
            state_next.type_cand    = type_cand;
            state_next.temp_latched = result.temp_out;
        end
    end

endmodule

`default_nettype wire

// ===== design/metar_cloud_group_parser_top.sv =====
// Top level of the cloud group parser: input register, parser state and
// result register around mcgp_step. Uses mcgp_pkg.
//
//   channel  | handshake                  | payload
//   item     | item_valid / item_stall    | mcgp_in_t  (ch, last, temporary)
//   result   | result_valid / result_stall| mcgp_out_t (one per token)
//
// One character per cycle while item_stall is low; the state update plus decode
// run while the character sits in the input register.
// A result is registered when its final character is processed.
// Reset returns the parser to the start of a token and empties both registers.
// Only a final character waiting on a stalled result register holds item_stall.
`default_nettype none

module metar_cloud_group_parser_top (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      item_valid,
    output logic                     item_stall,
    input  wire mcgp_pkg::mcgp_in_t  item,
    output logic                     result_valid,
    input  wire                      result_stall,
    output mcgp_pkg::mcgp_out_t      result
);
    import mcgp_pkg::*;

    logic        in_valid_reg;
    mcgp_in_t    in_data_reg;
    mcgp_state_t state_reg;
    mcgp_state_t state_next;
    logic        out_valid_reg;
    mcgp_out_t   out_data_reg;
    mcgp_out_t   step_result;
    logic        out_free;
    logic        process;

    mcgp_step u_step (
        .state      (state_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    assign out_free   = !out_valid_reg || !result_stall;
    // Non-final characters never wait on the result side.
    assign process    = in_valid_reg && (!in_data_reg.last || out_free);
    assign item_stall = in_valid_reg && !process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (!item_stall)
                in_valid_reg <= item_valid;
            if (process)
                state_reg <= state_next;
            if (out_free)
                out_valid_reg <= process && in_data_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            in_data_reg <= item;
        if (process && in_data_reg.last)
            out_data_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Input side is held back only by a blocked result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item_stall without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.matched) |->
            (!result.has_altitude && !result.has_type && result.altitude == '0))
        else $error("unmatched result carries decoded fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.has_type) |-> result.has_altitude)
        else $error("cloud type without altitude");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.altitude <= ALT_W'(ALT_MAX)))
        else $error("altitude above saturation limit");

    // A final character transfer restarts the token.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_data_reg.last) |=> (state_reg.position == '0))
        else $error("position not cleared after final character");

endmodule

`default_nettype wire
